[design/u8nf_pkg.sv]
package u8nf_pkg;

   typedef logic [20:0] cp_type;
   typedef logic [7:0]  byte_type;

   localparam cp_type CP_REPL = 21'h00FFFD;
   localparam cp_type CP_LF   = 21'h00000A;

   localparam byte_type BYTE_NUL  = 8'h00;
   localparam byte_type BYTE_LF   = 8'h0A;
   localparam byte_type BYTE_FF   = 8'h0C;
   localparam byte_type BYTE_CR   = 8'h0D;
   localparam byte_type ASCII_MAX = 8'h7F;

   localparam byte_type LEAD2_MIN = 8'hC2;
   localparam byte_type LEAD2_MAX = 8'hDF;
   localparam byte_type LEAD3_MIN = 8'hE0;
   localparam byte_type LEAD3_MAX = 8'hEF;
   localparam byte_type LEAD4_MIN = 8'hF0;
   localparam byte_type LEAD4_MAX = 8'hF4;

   localparam byte_type LEAD_E0 = 8'hE0;
   localparam byte_type LEAD_ED = 8'hED;
   localparam byte_type LEAD_F0 = 8'hF0;
   localparam byte_type LEAD_F4 = 8'hF4;

   localparam byte_type CONT_LO = 8'h80;
   localparam byte_type CONT_HI = 8'hBF;
   localparam byte_type E0_LO   = 8'hA0;
   localparam byte_type ED_HI   = 8'h9F;
   localparam byte_type F0_LO   = 8'h90;
   localparam byte_type F4_HI   = 8'h8F;

   // up to two code points caused by one input byte
   typedef struct packed {
      logic [1:0] count;
      cp_type     cp0;
      cp_type     cp1;
   } step_out_type;

   typedef struct packed {
      logic busy;      // sequence still open
      logic after_cr;  // last byte taken was a CR that did not end the text
   } step_status_type;

endpackage

[design/u8nf_if.sv]
interface u8nf_req_if;
   import u8nf_pkg::*;
   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     end_of_text;

   modport source (output valid, output data_byte, output end_of_text, input ready);
   modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface u8nf_rsp_if;
   import u8nf_pkg::*;
   logic   valid;
   logic   ready;
   cp_type code_point;
   logic   run_last;

   modport source (output valid, output code_point, output run_last, input ready);
   modport sink   (input valid, input code_point, input run_last, output ready);
endinterface

[design/u8nf_step.sv]
module u8nf_step
   import u8nf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  byte_type        data_byte,
   input  logic            end_of_text,
   output step_out_type    step_out,
   output step_status_type step_status
);

   typedef enum logic [1:0] {
      LEAD_ASCII,
      LEAD_SEQ,
      LEAD_BAD
   } lead_class_type;

   logic [1:0] pend_ff, pend_in;
   cp_type     part_ff, part_in;
   byte_type   lo_ff, lo_in;
   byte_type   hi_ff, hi_in;
   logic       acr_ff, acr_in;

   lead_class_type lead_class;
   logic [1:0]     lead_pend;
   cp_type         lead_part;
   byte_type       lead_lo;
   byte_type       lead_hi;

   // lead byte classification
   always_comb begin
      lead_class = LEAD_BAD;
      lead_pend  = 2'd0;
      lead_part  = '0;
      lead_lo    = CONT_LO;
      lead_hi    = CONT_HI;
      if (data_byte <= ASCII_MAX) begin
         lead_class = LEAD_ASCII;
      end else if (data_byte >= LEAD2_MIN && data_byte <= LEAD2_MAX) begin
         lead_class = LEAD_SEQ;
         lead_pend  = 2'd1;
         lead_part  = {16'd0, data_byte[4:0]};
      end else if (data_byte >= LEAD3_MIN && data_byte <= LEAD3_MAX) begin
         lead_class = LEAD_SEQ;
         lead_pend  = 2'd2;
         lead_part  = {17'd0, data_byte[3:0]};
         if (data_byte == LEAD_E0) lead_lo = E0_LO;
         if (data_byte == LEAD_ED) lead_hi = ED_HI;
      end else if (data_byte >= LEAD4_MIN && data_byte <= LEAD4_MAX) begin
         lead_class = LEAD_SEQ;
         lead_pend  = 2'd3;
         lead_part  = {18'd0, data_byte[2:0]};
         if (data_byte == LEAD_F0) lead_lo = F0_LO;
         if (data_byte == LEAD_F4) lead_hi = F4_HI;
      end
   end

   logic   skip;
   logic   in_range;
   cp_type part_shift;
   cp_type ascii_cp;

   assign skip       = acr_ff && data_byte == BYTE_LF && pend_ff == 2'd0;
   assign in_range   = data_byte >= lo_ff && data_byte <= hi_ff;
   assign part_shift = {part_ff[14:0], data_byte[5:0]};

   always_comb begin
      case (data_byte)
         BYTE_CR, BYTE_FF: ascii_cp = CP_LF;
         BYTE_NUL:         ascii_cp = CP_REPL;
         default:          ascii_cp = {13'd0, data_byte};
      endcase
   end

   always_comb begin
      step_out.count = 2'd0;
      step_out.cp0   = CP_REPL;
      step_out.cp1   = CP_REPL;
      pend_in = pend_ff;
      part_in = part_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      acr_in  = 1'b0;

      if (!skip) begin
         if (pend_ff != 2'd0 && in_range) begin
            lo_in = CONT_LO;
            hi_in = CONT_HI;
            if (pend_ff == 2'd1) begin
               step_out.cp0   = part_shift;
               step_out.count = 2'd1;
               pend_in = 2'd0;
               part_in = '0;
            end else begin
               pend_in = pend_ff - 2'd1;
               part_in = part_shift;
            end
         end else begin
            // broken continuation: replacement, then the byte starts over
            if (pend_ff != 2'd0) begin
               step_out.cp0   = CP_REPL;
               step_out.count = 2'd1;
               pend_in = 2'd0;
               part_in = '0;
               lo_in   = CONT_LO;
               hi_in   = CONT_HI;
            end
            case (lead_class)
               LEAD_ASCII: begin
                  if (step_out.count == 2'd0) step_out.cp0 = ascii_cp;
                  else                        step_out.cp1 = ascii_cp;
                  step_out.count = step_out.count + 2'd1;
                  acr_in = data_byte == BYTE_CR;
               end
               LEAD_SEQ: begin
                  pend_in = lead_pend;
                  part_in = lead_part;
                  lo_in   = lead_lo;
                  hi_in   = lead_hi;
               end
               default: begin
                  pend_in = 2'd0;
                  part_in = '0;
                  lo_in   = CONT_LO;
                  hi_in   = CONT_HI;
                  if (step_out.count == 2'd0) step_out.cp0 = CP_REPL;
                  else                        step_out.cp1 = CP_REPL;
                  step_out.count = step_out.count + 2'd1;
               end
            endcase
         end
      end

      if (end_of_text) begin
         if (pend_in != 2'd0) begin
            if (step_out.count == 2'd0) step_out.cp0 = CP_REPL;
            else                        step_out.cp1 = CP_REPL;
            step_out.count = step_out.count + 2'd1;
         end
         pend_in = 2'd0;
         part_in = '0;
         lo_in   = CONT_LO;
         hi_in   = CONT_HI;
         acr_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
         part_ff <= '0;
         lo_ff   <= CONT_LO;
         hi_ff   <= CONT_HI;
         acr_ff  <= 1'b0;
      end else if (fire) begin
         pend_ff <= pend_in;
         part_ff <= part_in;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         acr_ff  <= acr_in;
      end
   end

   assign step_status.busy     = pend_ff != 2'd0;
   assign step_status.after_cr = acr_ff;

endmodule

[design/utf8_decode_with_newline_fold.sv]
// UTF-8 to code point decoder with CSS newline and NUL folding.
//
// req_ch: one byte per word, end_of_text set on the last byte of a text.
// rsp_ch: one code point per word; run_last marks the last code point
//   caused by an input byte. A byte gives zero, one or two code points.
// Path: a byte is taken into the input register, then decoded into the
//   two-entry result buffer, from which its code points are offered.
// Throughput: one byte per cycle while the receiver keeps rsp_ch.ready high
//   and every byte gives at most one code point; a byte that gives two holds
//   the decode stage while the result buffer drains, so the buffer's single
//   output port sets the rate.
// Reset (synchronous, active high) empties both stages and returns the
//   decoder to the start of a new text.
// When the receiver stalls, the pending result stays in the buffer; one
//   more byte is taken into the input register, then req_ch.ready drops
//   until the buffer has room for the next byte's results.
module utf8_decode_with_newline_fold
   import u8nf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   u8nf_req_if.sink   req_ch,
   u8nf_rsp_if.source rsp_ch
);

   logic     in_v_ff;
   byte_type in_byte_ff;
   logic     in_eot_ff;

   logic [1:0] cnt_ff;
   cp_type     slot0_ff;
   cp_type     slot1_ff;

   logic            pop;
   logic            out_free;
   logic            fire;
   step_out_type    step_out;
   step_status_type step_status;

   assign pop      = rsp_ch.valid && rsp_ch.ready;
   assign out_free = cnt_ff == 2'd0 || (cnt_ff == 2'd1 && rsp_ch.ready);
   assign fire     = in_v_ff && out_free;

   assign req_ch.ready = !in_v_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_v_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.data_byte;
         in_eot_ff  <= req_ch.end_of_text;
      end
   end

   u8nf_step u_step (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .data_byte   (in_byte_ff),
      .end_of_text (in_eot_ff),
      .step_out    (step_out),
      .step_status (step_status)
   );

   // whenever fire is high, the buffer holds exactly the new byte's code points after this cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (fire && step_out.count != 2'd0) begin
         cnt_ff <= step_out.count;
      end else if (pop) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && step_out.count != 2'd0) begin
         slot0_ff <= step_out.cp0;
         slot1_ff <= step_out.cp1;
      end else if (pop) begin
         slot0_ff <= slot1_ff;
      end
   end

   assign rsp_ch.valid      = cnt_ff != 2'd0;
   assign rsp_ch.code_point = slot0_ff;
   assign rsp_ch.run_last   = cnt_ff == 2'd1;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result buffer count out of range");

   a_pair_head_repl: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> slot0_ff == CP_REPL)
      else $error("first of two code points is not a replacement");

   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      fire && in_eot_ff |=> !step_status.busy && !step_status.after_cr)
      else $error("decoder state not cleared after end of text");

   a_cr_then_lf: assert property (@(posedge clock) disable iff (reset)
      step_status.after_cr |-> !step_status.busy)
      else $error("carriage return flag set inside a sequence");

endmodule
